### src/kmli_pkg.sv
`default_nettype none
package kmli_pkg;

    localparam int MAX_CENTERS = 8;
    localparam int MAX_DIM     = 4;
    localparam int MAX_POINTS  = 65536;

    localparam int CIDX_W     = 3;
    localparam int DIDX_W     = 2;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 17;
    localparam int DIST_W     = 64;
    localparam int QCNT_W     = $clog2(SUM_W);
    localparam int NC_W       = 4;
    localparam int ND_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM     = 2'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_CENTER = 1'b1;

    typedef logic [MAX_DIM-1:0][VAL_W-1:0] t_coord_vec;
    typedef logic [MAX_DIM-1:0][SUM_W-1:0] t_sum_vec;

    typedef struct packed {
        logic [DIST_W-1:0] dmin;
        logic [CIDX_W-1:0] idx;
    } t_tok;

    typedef struct packed {
        logic              wr_en;
        logic [DIDX_W-1:0] wr_crd;
        logic [VAL_W-1:0]  wr_val;
        logic              sq_en;
        logic [DIDX_W-1:0] pt_crd;
        logic [VAL_W-1:0]  pt_val;
        logic              dist_en;
        logic              dist_clr;
        logic              min_en;
        logic              acc_en;
        logic              acc_clr;
    } t_cell_ctl;

endpackage
`default_nettype wire

### src/kmli_cell.sv
`default_nettype none
module kmli_cell import kmli_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [CIDX_W-1:0] i_idx,
    input  wire logic              i_active,
    input  wire logic              i_sel,
    input  wire t_coord_vec        i_buf,
    input  wire t_tok              i_tok,
    output t_tok                   o_tok,
    output t_coord_vec             o_cent,
    output t_sum_vec               o_sums,
    output logic [CNT_W-1:0]       o_count
);

    t_coord_vec        r_cent;
    t_sum_vec          r_sums;
    logic [CNT_W-1:0]  r_count;
    logic [DIST_W-1:0] r_sq;
    logic [DIST_W-1:0] r_dist;
    t_tok              r_tok;

    logic [VAL_W-1:0]  cur;
    logic [VAL_W:0]    diff;
    logic [VAL_W:0]    neg_diff;
    logic [VAL_W-1:0]  mag;
    logic [DIST_W-1:0] n_sq;
    logic [DIST_W:0]   dsum;
    logic [DIST_W-1:0] n_dist;
    t_tok              n_tok;
    logic              do_acc;

    always_comb begin
        cur      = r_cent[i_ctl.pt_crd];
        diff     = {i_ctl.pt_val[VAL_W-1], i_ctl.pt_val} - {cur[VAL_W-1], cur};
        neg_diff = ~diff + 1'b1;
        mag      = diff[VAL_W] ? neg_diff[VAL_W-1:0] : diff[VAL_W-1:0];
        n_sq     = mag * mag;
        dsum     = {1'b0, r_dist} + {1'b0, r_sq};
        // The running distance sticks at all ones once it overflows.
        n_dist   = dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
        if (i_active && (r_dist < i_tok.dmin)) begin
            n_tok.dmin = r_dist;
            n_tok.idx  = i_idx;
        end else begin
            n_tok = i_tok;
        end
        do_acc = i_ctl.acc_en && i_sel && (r_count < CNT_W'(MAX_POINTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cent  <= '0;
            r_sums  <= '0;
            r_count <= '0;
            r_sq    <= '0;
            r_dist  <= '0;
            r_tok   <= '0;
        end else begin
            if (i_ctl.wr_en && i_sel) begin
                r_cent[i_ctl.wr_crd] <= i_ctl.wr_val;
            end
            if (i_ctl.sq_en) begin
                r_sq <= n_sq;
            end
            if (i_ctl.dist_clr) begin
                r_dist <= '0;
            end else if (i_ctl.dist_en && i_active) begin
                r_dist <= n_dist;
            end
            if (i_ctl.min_en) begin
                r_tok <= n_tok;
            end
            if (i_ctl.acc_clr) begin
                r_sums  <= '0;
                r_count <= '0;
            end else if (do_acc) begin
                for (int k = 0; k < MAX_DIM; k++) begin
                    r_sums[k] <= r_sums[k]
                        + {{(SUM_W-VAL_W){i_buf[k][VAL_W-1]}}, i_buf[k]};
                end
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_tok   = r_tok;
    assign o_cent  = r_cent;
    assign o_sums  = r_sums;
    assign o_count = r_count;

endmodule
`default_nettype wire

### src/kmli_div.sv
`default_nettype none
module kmli_div import kmli_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [VAL_W-1:0]      o_quot
);

    logic              r_run;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;

    logic [SUM_W-1:0]  mag;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              fits;
    logic [VAL_W-1:0]  q_low;

    always_comb begin
        mag     = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
        rem_sh  = {r_rem, r_q[SUM_W-1]};
        fits    = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
        q_low   = r_q[VAL_W-1:0];
    end

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= QCNT_W'(SUM_W - 1);
            end else if (r_run) begin
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_run) begin
            r_q   <= {r_q[SUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~q_low + 1'b1) : q_low;

endmodule
`default_nettype wire

### src/kmeans_lloyd_iteration.sv
`default_nettype none
// One Lloyd iteration of k-means on signed Q16.16 data, built as a row of eight
// centroid cells. A centroid load leaves busy low. A point
// coordinate keeps busy high after it is taken while every cell squares it and
// then accumulates; the last coordinate of a point then passes the nearest-centroid
// token down the cell row and emits the assignment. After the last point the block
// emits (clamped active_centers) * (clamped active_dim) centroid results: an empty
// cluster gives back its old centroid, and any other goes through the shared radix-2
// divider that takes one quotient bit per cycle over 48 bits. Results come one per
// strobe and cannot be held off, so take them as they appear.
module kmeans_lloyd_iteration import kmli_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_command,
    input  wire logic [CIDX_W-1:0]     i_center_index,
    input  wire logic [DIDX_W-1:0]     i_coord_index,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic                  i_last_coord,
    input  wire logic                  i_last_point,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_res_valid,
    output logic                       o_kind,
    output logic [CIDX_W-1:0]          o_cluster,
    output logic [DIDX_W-1:0]          o_coord_index_res,
    output logic signed [VAL_W-1:0]    o_value_res,
    output logic                       o_last
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_MIN  = 7'b0001000,
        S_ASN  = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_DIV  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [NC_W-1:0]   r_active_centers;
    logic [ND_W-1:0]   r_active_dim;
    t_coord_vec        r_buf;
    logic [DIDX_W-1:0] r_crd;
    logic [VAL_W-1:0]  r_val;
    logic              r_lc, r_lp, r_in_dim;
    logic [CIDX_W-1:0] r_mcnt, n_mcnt;
    logic [CIDX_W-1:0] r_j, n_j;
    logic [DIDX_W-1:0] r_k, n_k;

    logic              r_res_valid, n_res_valid;
    logic              r_kind, n_kind;
    logic [CIDX_W-1:0] r_cluster, n_cluster;
    logic [DIDX_W-1:0] r_cres, n_cres;
    logic [VAL_W-1:0]  r_vres, n_vres;
    logic              r_last, n_last;

    logic [NC_W-1:0]   nc_eff;
    logic [ND_W-1:0]   nd_eff;
    logic [CIDX_W-1:0] nc_last;
    logic [DIDX_W-1:0] nd_last;
    logic              accept;
    logic              pt_in_dim;
    t_coord_vec        buf_m;
    t_cell_ctl         ctl;
    logic [CIDX_W-1:0] sel_idx;
    logic              div_start, div_done;
    logic [VAL_W-1:0]  quot;
    logic              last_item;

    t_coord_vec       cent  [MAX_CENTERS];
    t_sum_vec         sums  [MAX_CENTERS];
    logic [CNT_W-1:0] cnt   [MAX_CENTERS];
    t_tok             tok   [MAX_CENTERS+1];

    always_comb begin
        if (r_active_centers == '0) begin
            nc_eff = NC_W'(1);
        end else if (r_active_centers > NC_W'(MAX_CENTERS)) begin
            nc_eff = NC_W'(MAX_CENTERS);
        end else begin
            nc_eff = r_active_centers;
        end
        if (r_active_dim == '0) begin
            nd_eff = ND_W'(1);
        end else if (r_active_dim > ND_W'(MAX_DIM)) begin
            nd_eff = ND_W'(MAX_DIM);
        end else begin
            nd_eff = r_active_dim;
        end
    end

    assign nc_last   = CIDX_W'(nc_eff - 1'b1);
    assign nd_last   = DIDX_W'(nd_eff - 1'b1);
    assign accept    = start && !busy;
    assign pt_in_dim = {1'b0, i_coord_index} < nd_eff;
    assign last_item = (r_j == nc_last) && (r_k == nd_last);
    assign busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int k = 0; k < MAX_DIM; k++) begin
            buf_m[k] = (ND_W'(k) < nd_eff) ? r_buf[k] : '0;
        end
    end

    assign tok[0] = '{dmin: '1, idx: '0};

    for (genvar g = 0; g < MAX_CENTERS; g++) begin : g_cell
        kmli_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_idx    (CIDX_W'(g)),
            .i_active (NC_W'(g) < nc_eff),
            .i_sel    (sel_idx == CIDX_W'(g)),
            .i_buf    (buf_m),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1]),
            .o_cent   (cent[g]),
            .o_sums   (sums[g]),
            .o_count  (cnt[g])
        );
    end

    kmli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sums[r_j][r_k]),
        .i_divisor  (cnt[r_j]),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        n_state     = r_state;
        n_mcnt      = r_mcnt;
        n_j         = r_j;
        n_k         = r_k;
        n_res_valid = 1'b0;
        n_kind      = KIND_ASSIGN;
        n_cluster   = '0;
        n_cres      = '0;
        n_vres      = '0;
        n_last      = 1'b0;
        div_start   = 1'b0;
        sel_idx     = r_j;
        ctl         = '0;
        ctl.pt_crd  = r_crd;
        ctl.pt_val  = r_val;
        ctl.wr_crd  = r_k;
        ctl.wr_val  = quot;

        case (r_state)
            S_IDLE: begin
                sel_idx     = i_center_index;
                ctl.wr_crd  = i_coord_index;
                ctl.wr_val  = i_value;
                if (accept) begin
                    if (i_command == CMD_LOAD) begin
                        ctl.wr_en = 1'b1;
                    end else begin
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                ctl.sq_en = r_in_dim;
                n_state   = S_ACC;
            end
            S_ACC: begin
                ctl.dist_en = r_in_dim;
                n_mcnt      = '0;
                n_j         = '0;
                n_k         = '0;
                if (r_lc) begin
                    n_state = S_MIN;
                end else if (r_lp) begin
                    // An unfinished point is dropped before the update.
                    ctl.dist_clr = 1'b1;
                    n_state      = S_UPD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MIN: begin
                ctl.min_en = 1'b1;
                n_mcnt     = r_mcnt + 1'b1;
                if (r_mcnt == CIDX_W'(MAX_CENTERS - 1)) begin
                    n_state = S_ASN;
                end
            end
            S_ASN: begin
                sel_idx      = tok[MAX_CENTERS].idx;
                ctl.acc_en   = 1'b1;
                ctl.dist_clr = 1'b1;
                n_res_valid  = 1'b1;
                n_kind       = KIND_ASSIGN;
                n_cluster    = tok[MAX_CENTERS].idx;
                n_state      = r_lp ? S_UPD : S_IDLE;
            end
            S_UPD: begin
                if (cnt[r_j] == '0) begin
                    n_res_valid = 1'b1;
                    n_kind      = KIND_CENTER;
                    n_cluster   = r_j;
                    n_cres      = r_k;
                    n_vres      = cent[r_j][r_k];
                    n_last      = last_item;
                    if (last_item) begin
                        ctl.acc_clr = 1'b1;
                        n_state     = S_IDLE;
                    end else if (r_k == nd_last) begin
                        n_k = '0;
                        n_j = r_j + 1'b1;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    ctl.wr_en   = 1'b1;
                    n_res_valid = 1'b1;
                    n_kind      = KIND_CENTER;
                    n_cluster   = r_j;
                    n_cres      = r_k;
                    n_vres      = quot;
                    n_last      = last_item;
                    if (last_item) begin
                        ctl.acc_clr = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_UPD;
                        if (r_k == nd_last) begin
                            n_k = '0;
                            n_j = r_j + 1'b1;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_active_centers <= NC_W'(8);
            r_active_dim     <= ND_W'(4);
            r_mcnt           <= '0;
            r_j              <= '0;
            r_k              <= '0;
            r_res_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mcnt      <= n_mcnt;
            r_j         <= n_j;
            r_k         <= n_k;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CENTERS: r_active_centers <= i_cfg_data[NC_W-1:0];
                    CFG_DIM:     r_active_dim     <= i_cfg_data[ND_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_cluster <= n_cluster;
        r_cres    <= n_cres;
        r_vres    <= n_vres;
        r_last    <= n_last;
        if (accept && (i_command != CMD_LOAD)) begin
            r_crd    <= i_coord_index;
            r_val    <= i_value;
            r_lc     <= i_last_coord;
            r_lp     <= i_last_point;
            r_in_dim <= pt_in_dim;
            if (pt_in_dim) begin
                r_buf[i_coord_index] <= i_value;
            end
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_kind            = r_kind;
    assign o_cluster         = r_cluster;
    assign o_coord_index_res = r_cres;
    assign o_value_res       = r_vres;
    assign o_last            = r_last;

    a_res_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result strobe without work in progress");

    a_last_is_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_last) |-> (o_kind == KIND_CENTER))
        else $error("final result is not a centroid coordinate");

    a_assign_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_kind == KIND_ASSIGN)) |->
            (o_value_res == '0 && o_coord_index_res == '0 && !o_last))
        else $error("assignment result carries centroid payload");

endmodule
`default_nettype wire

### sim/kmeans_lloyd_iteration_tb.sv
`timescale 1ns / 1ps
module kmeans_lloyd_iteration_tb;
    import kmli_pkg::*;

    localparam logic CMD_POINT = 1'b1;
    localparam int   STALL_LIMIT = 20000;
    localparam int   SETTLE_CYCLES = 40;

    typedef struct {
        logic              cmd;
        logic [CIDX_W-1:0] ctr;
        logic [DIDX_W-1:0] crd;
        logic [VAL_W-1:0]  val;
        logic              lc;
        logic              lp;
    } t_coord_item;

    typedef struct {
        logic              kind;
        logic [CIDX_W-1:0] cl;
        logic [DIDX_W-1:0] ci;
        logic [VAL_W-1:0]  v;
        logic              last;
    } t_km_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_command = 1'b0;
    logic [CIDX_W-1:0]     i_center_index = '0;
    logic [DIDX_W-1:0]     i_coord_index = '0;
    logic [VAL_W-1:0]      i_value = '0;
    logic                  i_last_coord = 1'b0;
    logic                  i_last_point = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_res_valid;
    logic                  o_kind;
    logic [CIDX_W-1:0]     o_cluster;
    logic [DIDX_W-1:0]     o_coord_index_res;
    logic [VAL_W-1:0]      o_value_res;
    logic                  o_last;

    kmeans_lloyd_iteration u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_center_index(i_center_index),
        .i_coord_index(i_coord_index), .i_value(i_value),
        .i_last_coord(i_last_coord), .i_last_point(i_last_point),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_res_valid(o_res_valid), .o_kind(o_kind), .o_cluster(o_cluster),
        .o_coord_index_res(o_coord_index_res), .o_value_res(o_value_res),
        .o_last(o_last)
    );

    always #10 i_clk = ~i_clk;

    t_coord_item pend_q[$];
    t_km_result  expected_q[$];
    int          send_idle_pct = 0;
    int          errors = 0;
    int          stall_cycles = 0;
    bit          took = 1'b0;

    // Predicted block state.
    logic signed [VAL_W-1:0] cent[MAX_CENTERS][MAX_DIM];
    longint                  sums[MAX_CENTERS][MAX_DIM];
    int                      counts[MAX_CENTERS];
    logic [DIST_W-1:0]       pdist[MAX_CENTERS];
    logic signed [VAL_W-1:0] pbuf[MAX_DIM];
    logic [NC_W-1:0]         reg_centers = 4'd8;
    logic [ND_W-1:0]         reg_dim = 3'd4;

    // Generator's view of the centroids it has loaded, used to aim points.
    logic [VAL_W-1:0]        aim[MAX_CENTERS][MAX_DIM];
    int                      gen_nc = 8;
    int                      gen_nd = 4;

    function automatic int eff_centers();
        if (reg_centers == 0) return 1;
        if (reg_centers > MAX_CENTERS) return MAX_CENTERS;
        return int'(reg_centers);
    endfunction

    function automatic int eff_dim();
        if (reg_dim == 0) return 1;
        if (reg_dim > MAX_DIM) return MAX_DIM;
        return int'(reg_dim);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic push_result(input logic kind, input int cl, input int ci,
                               input logic [VAL_W-1:0] v, input logic last);
        t_km_result r;
        r.kind = kind;
        r.cl = cl[CIDX_W-1:0];
        r.ci = ci[DIDX_W-1:0];
        r.v = v;
        r.last = last;
        expected_q.push_back(r);
    endtask

    task automatic predict_lloyd(input t_coord_item it);
        int nc;
        int nd;
        int best;
        longint diff;
        logic [DIST_W-1:0] mag;
        logic [DIST_W-1:0] sq;
        nc = eff_centers();
        nd = eff_dim();
        if (it.cmd == CMD_LOAD) begin
            cent[it.ctr][it.crd] = it.val;
            return;
        end
        if (int'(it.crd) < nd) begin
            pbuf[it.crd] = it.val;
            for (int j = 0; j < nc; j++) begin
                diff = longint'($signed(it.val)) - longint'(cent[j][it.crd]);
                mag = diff < 0 ? -diff : diff;
                sq = mag * mag;
                if (~pdist[j] < sq) pdist[j] = '1;
                else pdist[j] = pdist[j] + sq;
            end
        end
        if (it.lc) begin
            best = 0;
            for (int j = 1; j < nc; j++)
                if (pdist[j] < pdist[best]) best = j;
            if (counts[best] < MAX_POINTS) begin
                for (int k = 0; k < nd; k++) sums[best][k] += longint'(pbuf[k]);
                counts[best]++;
            end
            push_result(KIND_ASSIGN, best, 0, '0, 1'b0);
        end
        if (it.lc || it.lp)
            for (int j = 0; j < MAX_CENTERS; j++) pdist[j] = '0;
        if (it.lp) begin
            for (int j = 0; j < nc; j++)
                for (int k = 0; k < nd; k++) begin
                    if (counts[j] != 0) cent[j][k] = VAL_W'(sums[j][k] / longint'(counts[j]));
                    push_result(KIND_CENTER, j, k, cent[j][k], j == nc - 1 && k == nd - 1);
                end
            for (int j = 0; j < MAX_CENTERS; j++) begin
                counts[j] = 0;
                for (int k = 0; k < MAX_DIM; k++) sums[j][k] = 0;
            end
        end
    endtask

    // Monitor, predictor hookup and watchdog.
    always @(posedge i_clk) begin
        t_km_result want;
        took = start && !busy && i_rst_n;
        if (took) begin
            t_coord_item it;
            it.cmd = i_command;
            it.ctr = i_center_index;
            it.crd = i_coord_index;
            it.val = i_value;
            it.lc = i_last_coord;
            it.lp = i_last_point;
            predict_lloyd(it);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_CENTERS) reg_centers = i_cfg_data[NC_W-1:0];
            else if (i_cfg_index == CFG_DIM) reg_dim = i_cfg_data[ND_W-1:0];
        end
        if (i_rst_n && o_res_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, cluster", 64'(o_cluster), '0);
            end else begin
                want = expected_q.pop_front();
                if (o_kind !== want.kind) report_mismatch("kind", 64'(o_kind), 64'(want.kind));
                if (o_cluster !== want.cl)
                    report_mismatch("cluster", 64'(o_cluster), 64'(want.cl));
                if (o_coord_index_res !== want.ci)
                    report_mismatch("coord_index_res", 64'(o_coord_index_res), 64'(want.ci));
                if (o_value_res !== want.v)
                    report_mismatch("value_res", 64'(o_value_res), 64'(want.v));
                if (o_last !== want.last) report_mismatch("last", 64'(o_last), 64'(want.last));
            end
        end
        if (took || o_res_valid || (i_cfg_valid && o_cfg_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Driver: one transaction per accepted start.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_coord_item it;
                it = pend_q.pop_front();
                start <= 1'b1;
                i_command <= it.cmd;
                i_center_index <= it.ctr;
                i_coord_index <= it.crd;
                i_value <= it.val;
                i_last_coord <= it.lc;
                i_last_point <= it.lp;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic add_item(input logic cmd, input int ctr, input int crd,
                            input logic [VAL_W-1:0] val, input logic lc, input logic lp);
        t_coord_item it;
        it.cmd = cmd;
        it.ctr = ctr[CIDX_W-1:0];
        it.crd = crd[DIDX_W-1:0];
        it.val = val;
        it.lc = lc;
        it.lp = lp;
        if (cmd == CMD_LOAD) aim[it.ctr][it.crd] = val;
        pend_q.push_back(it);
    endtask

    function automatic logic [VAL_W-1:0] spread(input int scale);
        case (scale)
            0: return VAL_W'($signed($urandom_range(0, 511)) - 256);
            1: return VAL_W'($signed($urandom_range(0, 2097151)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    // One data set: centroid loads, a stream of points, last point at the end.
    task automatic add_data_set(input int npts, output int added);
        int scale;
        int tgt;
        int ncrd;
        int crd;
        bit early_end;
        added = 0;
        scale = $urandom_range(0, 2);
        for (int j = 0; j < gen_nc; j++)
            for (int k = 0; k < gen_nd; k++)
                if ($urandom_range(0, 3) != 0) begin
                    add_item(CMD_LOAD, j, k, spread(scale), 1'($urandom), 1'($urandom));
                    added++;
                end
        early_end = $urandom_range(0, 9) == 0;
        for (int p = 0; p < npts; p++) begin
            tgt = $urandom_range(0, gen_nc - 1);
            if ($urandom_range(0, 9) == 0) begin
                add_item(CMD_LOAD, $urandom_range(0, 7), $urandom_range(0, 3), $urandom,
                         1'($urandom), 1'($urandom));
                added++;
            end
            if ($urandom_range(0, 6) != 0) begin
                for (int k = 0; k < gen_nd; k++) begin
                    add_item(CMD_POINT, $urandom, k, aim[tgt][k] + spread(0),
                             k == gen_nd - 1, p == npts - 1 && k == gen_nd - 1 && !early_end);
                    added++;
                end
            end else begin
                // Broken point: stray, repeated or missing coordinates.
                ncrd = $urandom_range(1, 5);
                for (int k = 0; k < ncrd; k++) begin
                    crd = $urandom_range(0, 3);
                    add_item(CMD_POINT, $urandom, crd, aim[tgt][crd] + spread(scale),
                             k == ncrd - 1, p == npts - 1 && k == ncrd - 1 && !early_end);
                    added++;
                end
            end
        end
        if (early_end) begin
            // Last point flagged on a coordinate that does not end its point.
            add_item(CMD_POINT, $urandom, $urandom_range(0, 3), $urandom, 1'b0, 1'b1);
            added++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= {4'($urandom_range(0, 15)), val[3:0]};
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || start) @(negedge i_clk);
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_active(input int centers, input int dim);
        write_reg(CFG_CENTERS, centers);
        write_reg(CFG_DIM, dim);
        gen_nc = centers == 0 ? 1 : (centers > MAX_CENTERS ? MAX_CENTERS : centers);
        gen_nd = dim == 0 ? 1 : (dim > MAX_DIM ? MAX_DIM : dim);
    endtask

    initial begin
        int budget;
        int n;
        int phase_centers[6] = '{8, 1, 0, 15, 3, 5};
        int phase_dim[6]     = '{4, 1, 7, 0, 2, 3};
        int phase_idle[6]    = '{0, 61, 12, 0, 61, 12};
        for (int j = 0; j < MAX_CENTERS; j++) begin
            counts[j] = 0;
            pdist[j] = '0;
            for (int k = 0; k < MAX_DIM; k++) begin
                cent[j][k] = '0;
                sums[j][k] = 0;
                aim[j][k] = '0;
            end
        end
        for (int k = 0; k < MAX_DIM; k++) pbuf[k] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: centroids 0 and 1 stay zero and tie, 2 sits at the most
        // negative corner and 3 at the most positive one.
        for (int k = 0; k < MAX_DIM; k++) add_item(CMD_LOAD, 2, k, 32'h8000_0000, 1'b1, 1'b0);
        for (int k = 0; k < MAX_DIM; k++) add_item(CMD_LOAD, 3, k, 32'h7fff_ffff, 1'b0, 1'b1);
        for (int k = 0; k < MAX_DIM; k++) add_item(CMD_POINT, 7, k, '0, k == 3, 1'b0);
        for (int k = 0; k < MAX_DIM; k++)
            add_item(CMD_POINT, 0, k, 32'h7fff_ffff, k == 3, 1'b0);
        // On centroid 2 at the negative corner: distances to the positive corner saturate.
        for (int k = 0; k < MAX_DIM; k++)
            add_item(CMD_POINT, 5, k, 32'h8000_0000, k == 3, 1'b0);
        add_item(CMD_POINT, 0, 1, 32'h0001_0000, 1'b0, 1'b0);
        add_item(CMD_POINT, 0, 1, 32'hffff_0000, 1'b0, 1'b0);
        add_item(CMD_POINT, 0, 0, 32'h0000_8000, 1'b1, 1'b0);
        add_item(CMD_POINT, 0, 2, 32'h1234_5678, 1'b0, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                drain();
                set_active(phase_centers[ph], phase_dim[ph]);
            end
            send_idle_pct = phase_idle[ph];
            budget = 58;
            while (budget > 0) begin
                add_data_set($urandom_range(2, 9), n);
                budget -= n;
            end
        end
        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
